// ----- rtl/core/srb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the sequence reorder buffer
// Buffer sizing, controller states and the command / status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

  // buffer sizing
  localparam int BufferDepth = 16;
  localparam int SlotIdxW    = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int CountW      = $clog2(BufferDepth + 1);

  // field widths
  localparam int SeqW = 32;
  localparam int TagW = 32;

  // input operation codes
  localparam logic OpSample  = 1'b0;
  localparam logic OpRestart = 1'b1;

  // result status codes
  localparam logic StatusReleased = 1'b0;
  localparam logic StatusDropped  = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StArrive,
    StSearch,
    StTake
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic restart;   // empty the buffer, wait for a first sample
    logic store;     // append the sample to the buffer
    logic pass;      // full buffer, sample matches: hold it for release
    logic drop;      // full buffer, no match: send it back flagged
    logic search;    // compare all slots against the expected number
    logic take;      // pull the oldest match out of the buffer
    logic flush;     // send the held release as the final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;          // operation of the latched beat
    logic full;        // every slot occupied
    logic seq_match;   // latched number equals the expected one
    logic any_hit;     // some slot matched in the last search
    logic pend_valid;  // a release is held back
    logic out_free;    // output register can take a beat this cycle
  } sts_t;

endpackage

// ----- rtl/core/srb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_in_if: input channel of the sequence reorder buffer
// Valid / ready handshake carrying an operation, a sequence number and a tag.
// ----------------------------------------------------------------------------
interface srb_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [srb_pkg::SeqW-1:0] seq_in;
  logic [srb_pkg::TagW-1:0] tag_in;

  modport source (output valid, output op, output seq_in, output tag_in, input ready);
  modport sink   (input valid, input op, input seq_in, input tag_in, output ready);
endinterface

// ----- rtl/core/srb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_out_if: result channel of the sequence reorder buffer
// Valid / ready handshake carrying a released or dropped sample.
// ----------------------------------------------------------------------------
interface srb_out_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::SeqW-1:0] seq_out;
  logic [srb_pkg::TagW-1:0] tag_out;
  logic                     status;
  logic                     last;

  modport source (output valid, output seq_out, output tag_out, output status,
                  output last, input ready);
  modport sink   (input valid, input seq_out, input tag_out, input status,
                  input last, output ready);
endinterface

// ----- rtl/core/srb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ctrl: controller of the sequence reorder buffer
// Sequences arrival, match search and release of one input beat at a time.
// ----------------------------------------------------------------------------
module srb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srb_pkg::sts_t   sts_i,
  output srb_pkg::cmd_t   cmd_o
);

  srb_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = srb_pkg::StArrive;
        end
      end
      srb_pkg::StArrive: begin
        if (sts_i.op == srb_pkg::OpRestart) begin
          cmd_o.restart = 1'b1;
          state_d       = srb_pkg::StIdle;
        end else if (!sts_i.full) begin
          cmd_o.store = 1'b1;
          state_d     = srb_pkg::StSearch;
        end else if (sts_i.seq_match) begin
          cmd_o.pass = 1'b1;
          state_d    = srb_pkg::StSearch;
        end else if (sts_i.out_free) begin
          cmd_o.drop = 1'b1;
          state_d    = srb_pkg::StIdle;
        end
      end
      srb_pkg::StSearch: begin
        cmd_o.search = 1'b1;
        state_d      = srb_pkg::StTake;
      end
      srb_pkg::StTake: begin
        if (sts_i.any_hit) begin
          // a held release goes out as non-final before the next one is held
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.take = 1'b1;
            state_d    = srb_pkg::StSearch;
          end
        end else if (sts_i.pend_valid) begin
          if (sts_i.out_free) begin
            cmd_o.flush = 1'b1;
            state_d     = srb_pkg::StIdle;
          end
        end else begin
          state_d = srb_pkg::StIdle;
        end
      end
      default: begin
        state_d = srb_pkg::StIdle;
      end
    endcase
  end

endmodule

// ----- rtl/core/srb_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_dpath: datapath of the sequence reorder buffer
// Arrival-ordered slot registers, expected number, match search, held
// release and output register.
// ----------------------------------------------------------------------------
module srb_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     op_i,
  input  logic [srb_pkg::SeqW-1:0] seq_i,
  input  logic [srb_pkg::TagW-1:0] tag_i,
  input  srb_pkg::cmd_t            cmd_i,
  output srb_pkg::sts_t            sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [srb_pkg::SeqW-1:0] out_seq_o,
  output logic [srb_pkg::TagW-1:0] out_tag_o,
  output logic                     out_status_o,
  output logic                     out_last_o
);

  localparam int Depth = srb_pkg::BufferDepth;

  // latched input beat
  logic                     in_op_q;
  logic [srb_pkg::SeqW-1:0] in_seq_q;
  logic [srb_pkg::TagW-1:0] in_tag_q;

  // slots, occupied prefix 0..count-1 in arrival order
  logic [srb_pkg::SeqW-1:0]   slot_seq_q [Depth];
  logic [srb_pkg::TagW-1:0]   slot_tag_q [Depth];
  logic [srb_pkg::CountW-1:0] count_q;

  logic [srb_pkg::SeqW-1:0] expected_q;
  logic                     awaiting_q;
  logic [Depth-1:0]         hit_q;

  // held release
  logic                     pend_valid_q;
  logic [srb_pkg::SeqW-1:0] pend_seq_q;
  logic [srb_pkg::TagW-1:0] pend_tag_q;

  // output register
  logic                     out_valid_q;
  logic [srb_pkg::SeqW-1:0] out_seq_q;
  logic [srb_pkg::TagW-1:0] out_tag_q;
  logic                     out_status_q;
  logic                     out_last_q;

  logic [srb_pkg::SeqW-1:0]     exp_eff;
  logic                         out_free;
  logic                         out_load;
  logic [srb_pkg::SlotIdxW-1:0] take_idx;
  logic [srb_pkg::SeqW-1:0]     take_seq;
  logic [srb_pkg::TagW-1:0]     take_tag;

  // the first sample after a restart sets the expected number
  assign exp_eff  = awaiting_q ? in_seq_q : expected_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.drop || cmd_i.flush || (cmd_i.take && pend_valid_q);

  // oldest matching slot
  always_comb begin
    take_idx = '0;
    take_seq = slot_seq_q[0];
    take_tag = slot_tag_q[0];
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        take_idx = srb_pkg::SlotIdxW'(i);
        take_seq = slot_seq_q[i];
        take_tag = slot_tag_q[i];
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_op_q  <= op_i;
      in_seq_q <= seq_i;
      in_tag_q <= tag_i;
    end
  end

  // slot payload: append at the fill point, shift down on removal
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (cmd_i.store && (srb_pkg::CountW'(i) == count_q)) begin
        slot_seq_q[i] <= in_seq_q;
        slot_tag_q[i] <= in_tag_q;
      end else if (cmd_i.take && (i < Depth - 1) &&
                   (srb_pkg::SlotIdxW'(i) >= take_idx)) begin
        slot_seq_q[i] <= slot_seq_q[(i < Depth - 1) ? i + 1 : i];
        slot_tag_q[i] <= slot_tag_q[(i < Depth - 1) ? i + 1 : i];
      end
    end
  end

  // match vector against the expected number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else if (cmd_i.search) begin
      for (int i = 0; i < Depth; i++) begin
        hit_q[i] <= (srb_pkg::CountW'(i) < count_q) && (slot_seq_q[i] == expected_q);
      end
    end
  end

  // fill count, expected number and first-sample flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      expected_q <= '0;
      awaiting_q <= 1'b1;
    end else begin
      if (cmd_i.restart) begin
        count_q    <= '0;
        expected_q <= '0;
        awaiting_q <= 1'b1;
      end else if (cmd_i.store) begin
        count_q    <= count_q + 1'b1;
        expected_q <= exp_eff;
        awaiting_q <= 1'b0;
      end else if (cmd_i.pass) begin
        expected_q <= exp_eff + 1'b1;
        awaiting_q <= 1'b0;
      end else if (cmd_i.drop) begin
        expected_q <= exp_eff;
        awaiting_q <= 1'b0;
      end else if (cmd_i.take) begin
        count_q    <= count_q - 1'b1;
        expected_q <= expected_q + 1'b1;
      end
    end
  end

  // held release, sent once the next search shows whether it is final
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pass || cmd_i.take) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush || cmd_i.restart) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass) begin
      pend_seq_q <= in_seq_q;
      pend_tag_q <= in_tag_q;
    end else if (cmd_i.take) begin
      pend_seq_q <= take_seq;
      pend_tag_q <= take_tag;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.drop) begin
      out_seq_q    <= in_seq_q;
      out_tag_q    <= in_tag_q;
      out_status_q <= srb_pkg::StatusDropped;
      out_last_q   <= 1'b1;
    end else if (out_load) begin
      out_seq_q    <= pend_seq_q;
      out_tag_q    <= pend_tag_q;
      out_status_q <= srb_pkg::StatusReleased;
      out_last_q   <= cmd_i.flush;
    end
  end

  // status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = in_op_q;
    sts_o.full       = (count_q >= srb_pkg::CountW'(Depth));
    sts_o.seq_match  = (in_seq_q == exp_eff);
    sts_o.any_hit    = |hit_q;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_seq_o    = out_seq_q;
  assign out_tag_o    = out_tag_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/core/sequence_reorder_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer: reorders samples by sequence number
//
//   channel   dir   beat contents                  accepted when
//   in_i      in    op, seq_in, tag_in             in_i.valid && in_i.ready
//   out_o     out   seq_out, tag_out, status, last out_o.valid && out_o.ready
//
// One beat is worked on at a time. A restart or a dropped sample ends after the
// arrival step; a stored sample goes on to a search, then a take per release from
// the buffer, and a full-buffer match releases itself with no take of its own.
// The last search finds no match and sends the final release, if any.
// Each release is one pass of the match search over all slots. Reset empties
// the buffer at once with no clearing pass. A stalled output holds the
// controller before the next release or a drop is sent; input beats are only
// accepted between items.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  srb_in_if.sink     in_i,
  srb_out_if.source  out_o
);

  srb_pkg::cmd_t cmd;
  srb_pkg::sts_t sts;

  // controller
  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  srb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (in_i.op),
    .seq_i        (in_i.seq_in),
    .tag_i        (in_i.tag_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_seq_o    (out_o.seq_out),
    .out_tag_o    (out_o.tag_out),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last)
  );

  // a dropped sample is always the only, final result of its beat
  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == srb_pkg::StatusDropped) |-> out_o.last)
    else $error("dropped result without last");

  // no release is held back when a new beat is accepted
  a_no_pend_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !sts.pend_valid)
    else $error("input accepted with a release still held");

  // taking a match always leaves a release held
  a_take_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |=> sts.pend_valid)
    else $error("take without a held release");

  // the final release leaves the output loaded with last set
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> out_o.valid && out_o.last)
    else $error("final release not marked last");

endmodule

// ----- sim/sequence_reorder_buffer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_test: self-checking bench for the reorder buffer
// Sends directed and random sample / restart beats and predicts releases and
// drops from an in-bench model, but for typed rows. Output beats are compared
// field by field with the oldest predicted one. Both sides stall at random.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_test;

  typedef struct packed {
    logic [srb_pkg::SeqW-1:0] seq;
    logic [srb_pkg::TagW-1:0] tag;
    logic                     status;
    logic                     last;
  } release_t;

  typedef struct packed {
    logic [srb_pkg::SeqW-1:0] seq;
    logic [srb_pkg::TagW-1:0] tag;
  } held_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    logic                     op;
    logic [srb_pkg::SeqW-1:0] seq;
    logic [srb_pkg::TagW-1:0] tag;
    logic                     typed;
    logic                     one_result;
    logic [srb_pkg::SeqW-1:0] want_seq;
    logic [srb_pkg::TagW-1:0] want_tag;
    logic                     want_status;
  } stim_row_t;

  localparam int RandomBeats = 95;
  localparam int TailBeats   = 20;
  localparam int DrainCycles = 64;

  logic clk;
  logic rst_n;

  srb_in_if  in_if ();
  srb_out_if out_if ();

  sequence_reorder_buffer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // model state of the buffer
  held_t                    held_samples[$];
  logic [srb_pkg::SeqW-1:0] next_seq    = '0;
  logic                     await_first = 1'b1;

  release_t  step_releases[$];
  release_t  expected_releases[$];
  stim_row_t directed_rows[$];
  release_t  want;
  int        mismatch_count = 0;
  bit        tail_phase     = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] %s", $time, msg);
  endtask

  // predict the beats caused by one accepted input beat
  function automatic void reorder_predict(input logic op,
                                          input logic [srb_pkg::SeqW-1:0] seq,
                                          input logic [srb_pkg::TagW-1:0] tag);
    int       hit;
    release_t rel;
    held_t    h;
    step_releases.delete();
    if (op == srb_pkg::OpRestart) begin
      held_samples.delete();
      next_seq    = '0;
      await_first = 1'b1;
      return;
    end
    if (await_first) begin
      next_seq    = seq;
      await_first = 1'b0;
    end
    // full buffer: pass a match straight through, drop anything else
    if (held_samples.size() >= srb_pkg::BufferDepth) begin
      rel.seq = seq;
      rel.tag = tag;
      if (seq != next_seq) begin
        rel.status = srb_pkg::StatusDropped;
        rel.last   = 1'b1;
        step_releases.insert(step_releases.size(), rel);
        return;
      end
      rel.status = srb_pkg::StatusReleased;
      rel.last   = 1'b0;
      step_releases.insert(step_releases.size(), rel);
      next_seq++;
    end else begin
      h.seq = seq;
      h.tag = tag;
      held_samples.insert(held_samples.size(), h);
    end
    // drain oldest matches while the expected number is held
    hit = 0;
    while (hit >= 0) begin
      hit = -1;
      for (int i = 0; i < held_samples.size(); i++)
        if (hit < 0 && held_samples[i].seq == next_seq) hit = i;
      if (hit >= 0) begin
        rel.seq    = held_samples[hit].seq;
        rel.tag    = held_samples[hit].tag;
        rel.status = srb_pkg::StatusReleased;
        rel.last   = 1'b0;
        step_releases.insert(step_releases.size(), rel);
        held_samples.delete(hit);
        next_seq++;
      end
    end
    if (step_releases.size() > 0)
      step_releases[step_releases.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_row(input logic op, input logic [srb_pkg::SeqW-1:0] seq,
                                  input logic [srb_pkg::TagW-1:0] tag, input logic typed,
                                  input logic one_result,
                                  input logic [srb_pkg::SeqW-1:0] want_seq,
                                  input logic [srb_pkg::TagW-1:0] want_tag,
                                  input logic want_status);
    stim_row_t row;
    row.op          = op;
    row.seq         = seq;
    row.tag         = tag;
    row.typed       = typed;
    row.one_result  = one_result;
    row.want_seq    = want_seq;
    row.want_tag    = want_tag;
    row.want_status = want_status;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // drive one beat and hold it until the handshake completes
  task automatic send_beat(input logic op, input logic [srb_pkg::SeqW-1:0] seq,
                           input logic [srb_pkg::TagW-1:0] tag);
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.seq_in <= seq;
    in_if.tag_in <= tag;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // optional sender gap, then one beat, then its predicted results
  task automatic issue_beat(input logic op, input logic [srb_pkg::SeqW-1:0] seq,
                            input logic [srb_pkg::TagW-1:0] tag, input bit from_model);
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    send_beat(op, seq, tag);
    reorder_predict(op, seq, tag);
    if (from_model)
      foreach (step_releases[i])
        expected_releases.insert(expected_releases.size(), step_releases[i]);
  endtask

  // receiver stalls in bursts, none in the tail
  initial begin
    out_if.ready <= 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if (tail_phase) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_releases.size() == 0) begin
        report_mismatch($sformatf("unexpected beat seq %h tag %h", out_if.seq_out,
                                  out_if.tag_out));
      end else begin
        want = expected_releases.pop_front();
        if (want.seq !== out_if.seq_out)
          report_mismatch($sformatf("seq_out: expected %h, got %h", want.seq,
                                    out_if.seq_out));
        if (want.tag !== out_if.tag_out)
          report_mismatch($sformatf("tag_out: expected %h, got %h", want.tag,
                                    out_if.tag_out));
        if (want.status !== out_if.status)
          report_mismatch($sformatf("status: expected %b, got %b", want.status,
                                    out_if.status));
        if (want.last !== out_if.last)
          report_mismatch($sformatf("last: expected %b, got %b", want.last, out_if.last));
      end
    end
  end

  // stimulus
  initial begin
    int                       sent;
    int                       len;
    int                       j;
    logic [srb_pkg::SeqW-1:0] base;
    logic [srb_pkg::SeqW-1:0] swap;
    logic [srb_pkg::SeqW-1:0] burst[$];
    release_t                 typed_rel;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.op     <= srb_pkg::OpSample;
    in_if.seq_in <= '0;
    in_if.tag_in <= '0;

    // directed table: restart after reset, wrap of the expected number,
    // duplicate numbers, full buffer drop and full buffer match
    add_row(srb_pkg::OpRestart, '0, '0, 1'b1, 1'b0, '0, '0, srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 1'b1,
            32'hFFFF_FFFE, 32'h0000_0000, srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0,
            srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, '0, '0,
            srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0, '0, '0,
            srb_pkg::StatusReleased);
    add_row(srb_pkg::OpRestart, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0,
            srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'd100, 32'd1, 1'b1, 1'b1, 32'd100, 32'd1,
            srb_pkg::StatusReleased);
    for (int i = 0; i < srb_pkg::BufferDepth; i++)
      add_row(srb_pkg::OpSample, 32'd102 + i, 32'h0000_1000 + i, 1'b1, 1'b0, '0, '0,
              srb_pkg::StatusReleased);
    add_row(srb_pkg::OpSample, 32'd200, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'd200, 32'hDEAD_BEEF,
            srb_pkg::StatusDropped);
    add_row(srb_pkg::OpSample, 32'd101, 32'h0000_0000, 1'b0, 1'b0, '0, '0,
            srb_pkg::StatusReleased);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue_beat(directed_rows[i].op, directed_rows[i].seq, directed_rows[i].tag,
                 !directed_rows[i].typed);
      if (directed_rows[i].typed && directed_rows[i].one_result) begin
        typed_rel.seq    = directed_rows[i].want_seq;
        typed_rel.tag    = directed_rows[i].want_tag;
        typed_rel.status = directed_rows[i].want_status;
        typed_rel.last   = 1'b1;
        expected_releases.insert(expected_releases.size(), typed_rel);
      end
    end

    // hold off until every release is out
    in_if.valid <= 1'b0;
    while (expected_releases.size() != 0) @(posedge clk);

    // random runs of shuffled nearby numbers with gaps, duplicates and noise
    sent = 0;
    while (sent < RandomBeats) begin
      if (!await_first && ($urandom_range(0, 7) == 0 ||
          (held_samples.size() > srb_pkg::BufferDepth - 4 && $urandom_range(0, 1) == 0))) begin
        issue_beat(srb_pkg::OpRestart, $urandom, $urandom, 1'b1);
        sent++;
      end
      if (await_first)
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF8 : $urandom;
      else
        base = next_seq;
      len = $urandom_range(1, 20);
      burst.delete();
      for (int i = 0; i < len; i++) burst.insert(burst.size(), base + i);
      for (int i = len - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        swap     = burst[i];
        burst[i] = burst[j];
        burst[j] = swap;
      end
      case ($urandom_range(0, 9))
        0, 1: if (burst.size() > 1) burst.delete($urandom_range(0, burst.size() - 1));
        2: burst.insert(burst.size(), burst[$urandom_range(0, burst.size() - 1)]);
        3: burst[$urandom_range(0, burst.size() - 1)] = $urandom;
        default: ;
      endcase
      foreach (burst[i]) begin
        if (sent < RandomBeats) begin
          if (sent >= RandomBeats - TailBeats) tail_phase = 1'b1;
          issue_beat(srb_pkg::OpSample, burst[i], $urandom, 1'b1);
          sent++;
        end
      end
    end

    // drain
    in_if.valid <= 1'b0;
    while (expected_releases.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
